// ===== hdl/ior_pkg.sv =====
package ior_pkg;

  // Default sizing
  localparam int MAX_DIM_DEF    = 256;
  localparam int PIXEL_BITS_DEF = 32;

  // Register and field widths
  localparam int CFG_DIM_W  = 9;
  localparam int CFG_MODE_W = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int PIX_PORT_W = 32;

  // Register reset values
  localparam logic [CFG_DIM_W-1:0] DIM_RESET = 9'd256;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_ORIENT_MODE  = 2'd2,
    REG_UNUSED       = 2'd3
  } cfg_reg_t;

  // Orientation codes
  typedef enum logic [CFG_MODE_W-1:0] {
    MODE_NONE       = 3'd0,
    MODE_FLIP_H     = 3'd1,
    MODE_ROT180     = 3'd2,
    MODE_FLIP_V     = 3'd3,
    MODE_TRANSPOSE  = 3'd4,
    MODE_ROT90      = 3'd5,
    MODE_TRANSVERSE = 3'd6,
    MODE_ROT270     = 3'd7
  } orient_mode_t;

  // Transaction kinds
  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_DRAIN = 1'b1
  } action_t;

endpackage

// ===== hdl/ior_frame_store.sv =====
module ior_frame_store #(
  parameter int DEPTH = 65536,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wr_data,
  output logic [WIDTH-1:0]         rd_data_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port, one access per cycle, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[addr];
    end
  end

endmodule

// ===== hdl/ior_addr_gen.sv =====
module ior_addr_gen #(
  parameter int MAX_DIM = 256
) (
  input  logic                                       clk,
  input  logic                                       en,
  input  logic [ior_pkg::CFG_DIM_W-1:0]              cfg_width,
  input  logic [ior_pkg::CFG_DIM_W-1:0]              cfg_height,
  input  ior_pkg::orient_mode_t                      cfg_mode,
  input  logic [$clog2(MAX_DIM)-1:0]                 src_col,
  input  logic [$clog2(MAX_DIM+1)-1:0]               src_row,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]         row_base_r,
  output logic [$clog2(MAX_DIM)-1:0]                 col_r,
  output logic [$clog2(MAX_DIM*MAX_DIM+1)-1:0]       total_r,
  output logic [$clog2(MAX_DIM)-1:0]                 next_col_r,
  output logic [$clog2(MAX_DIM+1)-1:0]               next_row_r
);

  import ior_pkg::*;

  localparam int DW = $clog2(MAX_DIM + 1);
  localparam int CW = $clog2(MAX_DIM);
  localparam int AW = $clog2(MAX_DIM * MAX_DIM);
  localparam int TW = $clog2(MAX_DIM * MAX_DIM + 1);
  localparam int XW = (DW > CFG_DIM_W) ? DW : CFG_DIM_W;

  logic [XW-1:0]      w_ext, h_ext;
  logic [DW-1:0]      w, h, dw, x1;
  logic [CW-1:0]      x, y, xf, yf, col, row;
  logic [CW+DW-1:0]   prod;
  logic [2*DW-1:0]    area;
  logic [CW-1:0]      next_col;
  logic [DW-1:0]      next_row;

  // Clamp dimensions to 1..MAX_DIM
  always_comb begin
    w_ext = XW'(cfg_width);
    h_ext = XW'(cfg_height);
    if (w_ext == '0) begin
      w = DW'(1);
    end else if (w_ext > XW'(MAX_DIM)) begin
      w = DW'(MAX_DIM);
    end else begin
      w = DW'(w_ext);
    end
    if (h_ext == '0) begin
      h = DW'(1);
    end else if (h_ext > XW'(MAX_DIM)) begin
      h = DW'(MAX_DIM);
    end else begin
      h = DW'(h_ext);
    end
  end

  // Source position, clamped into the current frame
  always_comb begin
    if (DW'(src_col) < w) begin
      x = src_col;
    end else begin
      x = CW'(w - DW'(1));
    end
    if (src_row < h) begin
      y = CW'(src_row);
    end else begin
      y = CW'(h - DW'(1));
    end
    xf = CW'(w - DW'(1) - DW'(x));
    yf = CW'(h - DW'(1) - DW'(y));
  end

  // Destination column, row and row pitch per orientation
  always_comb begin
    unique case (cfg_mode)
      MODE_NONE:       begin col = x;  row = y;  dw = w; end
      MODE_FLIP_H:     begin col = xf; row = y;  dw = w; end
      MODE_ROT180:     begin col = xf; row = yf; dw = w; end
      MODE_FLIP_V:     begin col = x;  row = yf; dw = w; end
      MODE_TRANSPOSE:  begin col = y;  row = x;  dw = h; end
      MODE_ROT90:      begin col = yf; row = x;  dw = h; end
      MODE_TRANSVERSE: begin col = yf; row = xf; dw = h; end
      MODE_ROT270:     begin col = y;  row = xf; dw = h; end
      default:         begin col = x;  row = y;  dw = w; end
    endcase
  end

  // One multiplier each for the row base and the frame size
  always_comb begin
    prod = (CW+DW)'(row) * (CW+DW)'(dw);
    area = (2*DW)'(w) * (2*DW)'(h);
  end

  // Raster advance of the source position
  always_comb begin
    x1 = DW'(x) + DW'(1);
    if (x1 >= w) begin
      next_col = '0;
      next_row = DW'(y) + DW'(1);
    end else begin
      next_col = CW'(x1);
      next_row = DW'(y);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      row_base_r <= AW'(prod);
      col_r      <= col;
      total_r    <= TW'(area);
      next_col_r <= next_col;
      next_row_r <= next_row;
    end
  end

endmodule

// ===== hdl/image_orientation_transform_top.sv =====
// Channel  | Ports                                   | Transfer
// ---------+-----------------------------------------+--------------------------------
// input    | start, busy, in_action, in_pixel_in     | start high while busy low
// result   | out_valid, out_pixel_out, out_last_pixel| one-cycle strobe, no backpressure
// config   | cfg_valid, cfg_ready, cfg_index, cfg_data| valid and ready both high
//
// A load transaction keeps busy high after it is taken through address math with its
// multiplier, then the frame store write; no new load is taken until busy falls.
// A drain that yields a pixel keeps busy high through the address step, the store read and
// the result state, the last carrying out_valid; no new drain is taken until busy falls.
// rst_n is synchronous, active low; it clears state, counters and config registers, not the capture or the store.
// Results cannot be stalled; each appears for exactly one cycle.
module image_orientation_transform_top #(
  parameter int MAX_DIM    = ior_pkg::MAX_DIM_DEF,
  parameter int PIXEL_BITS = ior_pkg::PIXEL_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_action,
  input  logic [ior_pkg::PIX_PORT_W-1:0] in_pixel_in,
  output logic                           out_valid,
  output logic [ior_pkg::PIX_PORT_W-1:0] out_pixel_out,
  output logic                           out_last_pixel,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ior_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ior_pkg::CFG_DATA_W-1:0] cfg_data
);

  import ior_pkg::*;

  localparam int DW    = $clog2(MAX_DIM + 1);
  localparam int CW    = $clog2(MAX_DIM);
  localparam int AW    = $clog2(MAX_DIM * MAX_DIM);
  localparam int TW    = $clog2(MAX_DIM * MAX_DIM + 1);
  localparam int DEPTH = MAX_DIM * MAX_DIM;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CALC = 4'b0010,
    ST_EXEC = 4'b0100,
    ST_READ = 4'b1000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CFG_DIM_W-1:0]    width_r, height_r;
  orient_mode_t            mode_r;
  action_t                 action_r;
  logic [PIXEL_BITS-1:0]   pixel_r;
  logic [CW-1:0]           src_col_r, src_col_nxt;
  logic [DW-1:0]           src_row_r, src_row_nxt;
  logic [TW-1:0]           loaded_r, loaded_nxt;
  logic [TW-1:0]           drain_r, drain_nxt;
  logic                    last_r, last_nxt;

  logic [AW-1:0]           row_base;
  logic [CW-1:0]           col;
  logic [TW-1:0]           total;
  logic [CW-1:0]           step_col;
  logic [DW-1:0]           step_row;

  logic [TW-1:0]           total_m1, pos;
  logic [AW-1:0]           mem_addr;
  logic                    mem_wr, mem_rd, frame_full, is_last;
  logic [PIXEL_BITS-1:0]   rd_data;

  logic                    accept;

  assign accept    = start && !busy;
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_RESET;
      height_r <= DIM_RESET;
      mode_r   <= MODE_NONE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:  width_r  <= cfg_data;
        REG_IMAGE_HEIGHT: height_r <= cfg_data;
        REG_ORIENT_MODE:  mode_r   <= orient_mode_t'(cfg_data[CFG_MODE_W-1:0]);
        REG_UNUSED:       ;
        default:          ;
      endcase
    end
  end

  // Capture the transaction
  always_ff @(posedge clk) begin
    if (accept) begin
      action_r <= action_t'(in_action);
      pixel_r  <= PIXEL_BITS'(in_pixel_in);
    end
  end

  ior_addr_gen #(
    .MAX_DIM (MAX_DIM)
  ) u_addr (
    .clk        (clk),
    .en         (state_r == ST_CALC),
    .cfg_width  (width_r),
    .cfg_height (height_r),
    .cfg_mode   (mode_r),
    .src_col    (src_col_r),
    .src_row    (src_row_r),
    .row_base_r (row_base),
    .col_r      (col),
    .total_r    (total),
    .next_col_r (step_col),
    .next_row_r (step_row)
  );

  // Execute step: store write for loads until the frame is full, store read for drains once it is full
  always_comb begin
    total_m1    = total - TW'(1);
    frame_full  = (loaded_r >= total);
    pos         = (drain_r < total_m1) ? drain_r : total_m1;
    is_last     = (pos == total_m1);
    mem_wr      = 1'b0;
    mem_rd      = 1'b0;
    mem_addr    = row_base + AW'(col);
    src_col_nxt = src_col_r;
    src_row_nxt = src_row_r;
    loaded_nxt  = loaded_r;
    drain_nxt   = drain_r;
    last_nxt    = last_r;
    if (state_r == ST_EXEC) begin
      if (action_r == ACT_LOAD) begin
        if (!frame_full) begin
          mem_wr      = 1'b1;
          src_col_nxt = step_col;
          src_row_nxt = step_row;
          loaded_nxt  = loaded_r + TW'(1);
        end
      end else if (frame_full) begin
        mem_rd   = 1'b1;
        mem_addr = AW'(pos);
        last_nxt = is_last;
        if (is_last) begin
          src_col_nxt = '0;
          src_row_nxt = '0;
          loaded_nxt  = '0;
          drain_nxt   = '0;
        end else begin
          drain_nxt = pos + TW'(1);
        end
      end
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_CALC;
      ST_CALC: state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = mem_rd ? ST_READ : ST_IDLE;
      ST_READ: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      src_col_r <= '0;
      src_row_r <= '0;
      loaded_r  <= '0;
      drain_r   <= '0;
      last_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      src_col_r <= src_col_nxt;
      src_row_r <= src_row_nxt;
      loaded_r  <= loaded_nxt;
      drain_r   <= drain_nxt;
      last_r    <= last_nxt;
    end
  end

  ior_frame_store #(
    .DEPTH (DEPTH),
    .WIDTH (PIXEL_BITS)
  ) u_store (
    .clk       (clk),
    .wr_en     (mem_wr),
    .rd_en     (mem_rd),
    .addr      (mem_addr),
    .wr_data   (pixel_r),
    .rd_data_r (rd_data)
  );

  // Result strobe comes in the cycle after the read
  assign out_valid      = (state_r == ST_READ);
  assign out_pixel_out  = PIX_PORT_W'(rd_data);
  assign out_last_pixel = last_r;

endmodule

// ===== hdl/ior_checker.sv =====
module ior_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic out_last_pixel
);

  // A taken transaction always occupies the block
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("transaction taken but block not busy");

  // Results only appear while a transaction is in flight
  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe outside a transaction");

  // A result ends its transaction
  a_result_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy && !out_valid)
    else $error("block still busy after result");

  // A drain result shows only after busy was high through the address and read steps
  a_result_delay: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy) && $past(busy, 2))
    else $error("result came too early");

  // The last-pixel flag only moves together with a result
  a_last_steady: assert property (@(posedge clk) disable iff (!rst_n)
    $changed(out_last_pixel) |-> out_valid)
    else $error("last pixel flag changed without a result");

endmodule

bind image_orientation_transform_top ior_checker u_ior_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_last_pixel (out_last_pixel)
);
